// File: rtl/mbac_pkg.sv
package mbac_pkg;

  // number of shares built for each bit, 2 or 3
  localparam int unsigned SHARE_COUNT = 3;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned SHARES_MAX = 3;
  localparam int unsigned KB_W       = 5;
  localparam int unsigned BOOL_W     = 3;
  localparam int unsigned RAND_W     = 48;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [KB_W-1:0] KB_RESET = KB_W'(13);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [SHARES_MAX-1:0] share_vec_t;

  typedef struct packed {
    logic take;
    logic last;
  } acc_ctl_t;

  // low-bit mask for a modulus width, widths above sixteen saturate
  function automatic word_t kb_mask(logic [KB_W-1:0] kb);
    word_t m;
    if (kb >= KB_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << kb[3:0]) - word_t'(1);
    end
    return m;
  endfunction

endpackage

// File: rtl/mbac_convert.sv
module mbac_convert (
  input  logic [mbac_pkg::BOOL_W-1:0] bool_bits_i,
  input  logic [mbac_pkg::RAND_W-1:0] rand_convert_i,
  input  logic [mbac_pkg::RAND_W-1:0] rand_refresh_i,
  input  mbac_pkg::word_t             mask_i,
  output mbac_pkg::share_vec_t        shares_o
);
  import mbac_pkg::*;

  word_t w0, w1, w2, r0, r1, r2;
  word_t x0, x1, x2;
  word_t b0, b1, b2;
  word_t t0, t1;
  word_t s0, s1, s2;

  // conditional negation: b - 2*b*x for a single bit x
  function automatic word_t cneg(word_t b, logic x);
    return x ? (word_t'(0) - b) : b;
  endfunction

  always_comb begin
    w0 = rand_convert_i[15:0]  & mask_i;
    w1 = rand_convert_i[31:16] & mask_i;
    w2 = rand_convert_i[47:32] & mask_i;
    r0 = rand_refresh_i[15:0]  & mask_i;
    r1 = rand_refresh_i[31:16] & mask_i;
    r2 = rand_refresh_i[47:32] & mask_i;
    x0 = word_t'(bool_bits_i[0]);
    x1 = word_t'(bool_bits_i[1]);
    x2 = word_t'(bool_bits_i[2]);

    // fold in share one
    t0 = (cneg((x0 - w0) & mask_i, bool_bits_i[1]) + x1) & mask_i;
    t1 = cneg(w0, bool_bits_i[1]) & mask_i;

    if (SHARE_COUNT > 2) begin
      // spread over a third share, then fold in share two
      b0 = (t0 - w1) & mask_i;
      b1 = (t1 - w2) & mask_i;
      b2 = (w1 + w2) & mask_i;
      s0 = (cneg(b0, bool_bits_i[2]) + x2) & mask_i;
      s1 = cneg(b1, bool_bits_i[2]) & mask_i;
      s2 = cneg(b2, bool_bits_i[2]) & mask_i;
      // pairwise refresh (0,1) (0,2) (1,2)
      shares_o[0] = (s0 + r0 + r1) & mask_i;
      shares_o[1] = (s1 - r0 + r2) & mask_i;
      shares_o[2] = (s2 - r1 - r2) & mask_i;
    end else begin
      b0 = '0;
      b1 = '0;
      b2 = '0;
      s0 = t0;
      s1 = t1;
      s2 = '0;
      shares_o[0] = (s0 + r0) & mask_i;
      shares_o[1] = (s1 - r0) & mask_i;
      shares_o[2] = s2;
    end
  end

endmodule

// File: rtl/mbac_accum.sv
module mbac_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mbac_pkg::acc_ctl_t   ctl_i,
  input  mbac_pkg::share_vec_t shares_i,
  input  mbac_pkg::word_t      mask_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_free_o,
  output mbac_pkg::share_vec_t out_shares_o
);
  import mbac_pkg::*;

  share_vec_t acc_q, acc_d;
  share_vec_t out_q;
  logic       first_q, first_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    for (int i = 0; i < SHARES_MAX; i++) begin
      acc_d[i] = ((first_q ? word_t'(0) : (acc_q[i] << 1)) + shares_i[i]) & mask_i;
    end
  end

  always_comb begin
    first_d     = first_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.take) begin
      first_d = ctl_i.last;
      if (ctl_i.last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      acc_q <= acc_d;
      if (ctl_i.last) begin
        out_q <= acc_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_free_o   = !out_valid_q || out_ready_i;
  assign out_shares_o = out_q;

endmodule

// File: rtl/masked_bool_to_arith_conversion_top.sv
// Masked Boolean-to-arithmetic converter. A value arrives as one bit of each Boolean
// share per transaction, most significant bit first, with fresh randoms; tlast marks
// the least significant bit. Each bit is turned into arithmetic shares modulo
// 2^modulus_bits and accumulated as acc = 2*acc + share; on tlast the three shares are
// delivered in one output transaction. Throughput is one bit per clock: a bit is
// registered at the input, then converted and accumulated as it moves on, so a result
// reaches the output register at the edge that moves its last bit out of the input
// register. The input stalls only when a last bit sits in the input register while
// the previous result still waits downstream. The user must write the modulus register
// through the cfg channel only while the block is idle; the block does not enforce it.
module masked_bool_to_arith_conversion_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbac_pkg::KB_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bool_bits [2:0], rand_convert [50:3], rand_refresh [98:51], zero [103:99]
  input  logic [mbac_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // share_zero [15:0], share_one [31:16], share_two [47:32]
  output logic [mbac_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import mbac_pkg::*;

  word_t                mask_q;
  logic                 in_valid_q;
  logic [BOOL_W-1:0]    bool_q;
  logic [RAND_W-1:0]    rc_q;
  logic [RAND_W-1:0]    rr_q;
  logic                 last_q;
  logic                 take;
  logic                 out_free;
  acc_ctl_t             ctl;
  share_vec_t           shares;
  share_vec_t           out_shares;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= kb_mask(KB_RESET);
    end else if (cfg_valid_i) begin
      mask_q <= kb_mask(cfg_data_i);
    end
  end

  // a non-last bit never needs the output register
  assign take          = in_valid_q && (!last_q || out_free);
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      bool_q <= s_axis_tdata[2:0];
      rc_q   <= s_axis_tdata[50:3];
      rr_q   <= s_axis_tdata[98:51];
      last_q <= s_axis_tlast;
    end
  end

  mbac_convert u_convert (
    .bool_bits_i    (bool_q),
    .rand_convert_i (rc_q),
    .rand_refresh_i (rr_q),
    .mask_i         (mask_q),
    .shares_o       (shares)
  );

  assign ctl.take = take;
  assign ctl.last = last_q;

  mbac_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .shares_i     (shares),
    .mask_i       (mask_q),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_free_o   (out_free),
    .out_shares_o (out_shares)
  );

  assign m_axis_tdata = {out_shares[2], out_shares[1], out_shares[0]};

endmodule

// File: rtl/mbac_checker.sv
module mbac_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [mbac_pkg::KB_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [mbac_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mbac_pkg::*;

  word_t mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= kb_mask(KB_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= kb_mask(cfg_data_i);
    end
  end

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // every share is reduced to the modulus
  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[15:0] & ~mask_q) == '0) &&
                      ((m_axis_tdata[31:16] & ~mask_q) == '0) &&
                      ((m_axis_tdata[47:32] & ~mask_q) == '0))
    else $error("share exceeds modulus");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("cfg write refused");

endmodule

bind masked_bool_to_arith_conversion_top mbac_checker u_mbac_checker (.*);

// File: tb/mbac_share_checker.sv
`timescale 1ns / 100ps
module mbac_share_checker
  import mbac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [KB_W-1:0]       cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // bool_bits [2:0], rand_convert [50:3], rand_refresh [98:51], zero [103:99]
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // share_zero [15:0], share_one [31:16], share_two [47:32]
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int unsigned           err_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  share_vec_t       expected_shares_q [$];
  logic [KB_W-1:0]  modulus_copy = KB_RESET;
  logic [31:0]      acc_shares [SHARES_MAX];
  logic             value_start = 1'b1;
  int unsigned      mismatches = 0;
  int unsigned      results_seen = 0;
  logic [4:0]       kb_eff;
  logic [31:0]      kb_mask_now;
  share_vec_t       bit_shares;
  share_vec_t       got_shares;
  share_vec_t       want_shares;
  logic [31:0]      prev_acc;
  string            field_name [SHARES_MAX] = '{"share_zero", "share_one", "share_two"};

  initial begin
    for (int k = 0; k < SHARES_MAX; k++) acc_shares[k] = '0;
  end

  function automatic logic [31:0] rand_word(logic [RAND_W-1:0] bundle, int unsigned idx);
    return {16'b0, bundle[16 * (idx % 3) +: 16]};
  endfunction

  // one bit position turned into arithmetic shares modulo 2^kb
  function automatic share_vec_t convert_bit(logic [BOOL_W-1:0] bits, logic [RAND_W-1:0] rc,
                                             logic [RAND_W-1:0] rr, logic [31:0] mask);
    logic [31:0] sh [SHARES_MAX];
    logic [31:0] b [SHARES_MAX];
    logic [31:0] xb;
    logic [31:0] r;
    int unsigned n;
    int unsigned used;
    int unsigned m;
    share_vec_t  res;
    n = (SHARE_COUNT < 2) ? 2 : ((SHARE_COUNT > 3) ? 3 : SHARE_COUNT);
    for (int k = 0; k < SHARES_MAX; k++) begin
      sh[k] = '0;
      b[k]  = '0;
    end
    sh[0] = 32'(bits[0]);
    used  = 0;
    for (int i = 1; i < n; i++) begin
      m     = i + 1;
      xb    = 32'(bits[i]);
      b[m-1] = rand_word(rc, used) & mask;
      used++;
      b[0] = (sh[0] - b[m-1]) & mask;
      // spread the existing shares over one more share
      for (int j = 1; j + 1 < m; j++) begin
        r = rand_word(rc, used) & mask;
        used++;
        b[j]   = (sh[j] - r) & mask;
        b[m-1] = (b[m-1] + r) & mask;
      end
      // x + a - 2ax applied share-wise, x added only to share zero
      for (int t = 0; t < m; t++) sh[t] = (b[t] - 2 * b[t] * xb) & mask;
      sh[0] = (sh[0] + xb) & mask;
    end
    used = 0;
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        r = rand_word(rr, used) & mask;
        used++;
        sh[i] = (sh[i] + r) & mask;
        sh[j] = (sh[j] - r) & mask;
      end
    end
    for (int k = 0; k < SHARES_MAX; k++) res[k] = sh[k][15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_copy = KB_RESET;
      value_start  = 1'b1;
      for (int k = 0; k < SHARES_MAX; k++) acc_shares[k] = '0;
      expected_shares_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) modulus_copy = cfg_data_i;

      if (s_tvalid_i && s_tready_i) begin
        kb_eff      = (modulus_copy > 5'd16) ? 5'd16 : modulus_copy;
        kb_mask_now = (32'd1 << kb_eff) - 32'd1;
        bit_shares  = convert_bit(s_tdata_i[BOOL_W-1:0], s_tdata_i[BOOL_W +: RAND_W],
                                  s_tdata_i[BOOL_W+RAND_W +: RAND_W], kb_mask_now);
        for (int k = 0; k < SHARES_MAX; k++) begin
          prev_acc      = value_start ? 32'd0 : acc_shares[k];
          acc_shares[k] = (2 * prev_acc + 32'(bit_shares[k])) & kb_mask_now;
        end
        if (s_tlast_i) begin
          for (int k = 0; k < SHARES_MAX; k++) want_shares[k] = acc_shares[k][15:0];
          expected_shares_q.push_back(want_shares);
          for (int k = 0; k < SHARES_MAX; k++) acc_shares[k] = '0;
          value_start = 1'b1;
        end else begin
          value_start = 1'b0;
        end
      end

      if (m_tvalid_i && m_tready_i) begin
        got_shares = m_tdata_i;
        if (expected_shares_q.size() == 0) begin
          report_mismatch("result with nothing expected, share_zero", got_shares[0], '0);
        end else begin
          want_shares = expected_shares_q.pop_front();
          results_seen++;
          for (int k = 0; k < SHARES_MAX; k++) begin
            if (got_shares[k] !== want_shares[k]) begin
              report_mismatch(field_name[k], got_shares[k], want_shares[k]);
            end
          end
        end
      end

      err_count_o <= mismatches;
      pending_o   <= expected_shares_q.size();
      checked_o   <= results_seen;
    end
  end

endmodule

// File: tb/tb_masked_bool_to_arith_conversion_top.sv
`timescale 1ns / 100ps
module tb_masked_bool_to_arith_conversion_top;
  import mbac_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SEG_ITEMS    = 130;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [KB_W-1:0]       cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // bool_bits [2:0], rand_convert [50:3], rand_refresh [98:51], zero [103:99]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // share_zero [15:0], share_one [31:16], share_two [47:32]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  masked_bool_to_arith_conversion_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mbac_share_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [RAND_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[RAND_W-1:0];
  endfunction

  // random words with a bias toward all zeros and all ones
  function automatic logic [RAND_W-1:0] pick_rand();
    logic [RAND_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = '1;
      default: v = rand48();
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [BOOL_W-1:0] bits, input logic [RAND_W-1:0] rc,
                           input logic [RAND_W-1:0] rr, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - BOOL_W - 2 * RAND_W){1'b0}}, rr, rc, bits};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // hold off the sender until every result is back and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [KB_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned seg_mod [9];
    int unsigned seg_items;
    int unsigned vlen;
    int unsigned tail;

    send_idle_pct = 33;
    recv_idle_pct = 75;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus, one-bit value on the very first transaction
    send_item(3'b111, '1, '1, 1'b1);
    // every boolean bit pattern in one value
    for (int k = 0; k < 8; k++) begin
      send_item(k[BOOL_W-1:0], (k % 2) ? '1 : '0, (k % 2) ? '0 : '1, k == 7);
    end
    // modulus changes in the middle of a value
    send_item(3'b011, rand48(), rand48(), 1'b0);
    send_item(3'b100, rand48(), rand48(), 1'b0);
    drain();
    write_modulus(KB_W'(16));
    send_item(3'b110, rand48(), rand48(), 1'b0);
    send_item(3'b001, rand48(), rand48(), 1'b1);
    drain();
    write_modulus(KB_W'(0));
    send_item(3'b111, '1, '1, 1'b0);
    send_item(3'b101, '1, '1, 1'b1);
    drain();
    write_modulus(KB_W'(31));
    for (int k = 0; k < 3; k++) send_item(3'b111, '1, '1, k == 2);
    drain();
    write_modulus(KB_W'(1));
    for (int k = 0; k < 3; k++) begin
      send_item(BOOL_W'($urandom_range(7)), rand48(), rand48(), k == 2);
    end

    seg_mod = '{1, 16, $urandom_range(2, 15), 0, 31, $urandom_range(1, 16),
                $urandom_range(17, 30), $urandom_range(1, 16), 13};
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 33; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        drain();
        write_modulus(KB_W'(seg_mod[3 * ph + s]));
        seg_items = 0;
        while (seg_items < SEG_ITEMS) begin
          vlen = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
          for (int k = 0; k < vlen; k++) begin
            send_item(BOOL_W'($urandom_range(7)), pick_rand(), pick_rand(), k == vlen - 1);
            seg_items++;
          end
        end
        // leave a value unfinished now and then so the next write lands inside it
        if ($urandom_range(1) == 1) begin
          tail = $urandom_range(1, 3);
          for (int k = 0; k < tail; k++) begin
            send_item(BOOL_W'($urandom_range(7)), rand48(), rand48(), 1'b0);
          end
        end
      end
    end

    drain();
    $display("sent %0d bit transactions under %0d modulus writes, idling on both sides",
             items_sent, settings_used);
    $display("checked %0d converted values share by share", checked);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
